// File: hw/rtl/dtq_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the due-time ordered task queue.
// Used by dtq_front, dtq_back and the top level; depends on nothing.
package dtq_pkg;

    localparam int KEY_W    = 31;
    localparam int CNT_W    = 5;
    localparam int STATUS_W = 3;

    // Raw operation field as it arrives on the input port
    typedef enum logic [1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_QUERY  = 2'd1,
        FUNC_PURGE  = 2'd2,
        FUNC_RSVD   = 2'd3
    } func_t;

    // Decoded command kind carried through the queue
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_QUERY  = 2'd1,
        OP_PURGE  = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_FOUND     = 3'd3,
        ST_NONE      = 3'd4,
        ST_PURGED    = 3'd5
    } status_t;

    typedef struct packed {
        op_t              op;
        logic [KEY_W-1:0] operand;   // due time for insert, now for query/purge
    } cmd_t;

endpackage

// File: hw/rtl/dtq_front.sv
`timescale 1ns / 1ps
// Front end: accepts input beats, decodes the operation, drops reserved codes
// and queues commands in a two-entry FIFO. Depends on dtq_pkg.
module dtq_front import dtq_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [1:0]       s_func,
    input  logic [KEY_W-1:0] s_due_time,
    input  logic [KEY_W-1:0] s_now_time,
    output logic             cmd_valid,
    output cmd_t             cmd,
    input  logic             cmd_pop
);

    localparam int QDEPTH = 2;

    cmd_t       slot_reg [QDEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       push;
    cmd_t       new_cmd;

    assign s_ready   = (fill_reg != 2'(QDEPTH));
    assign cmd_valid = (fill_reg != 2'd0);
    assign cmd       = slot_reg[rd_ptr_reg];

    always_comb begin
        new_cmd.operand = s_now_time;
        new_cmd.op      = OP_QUERY;
        unique case (s_func)
            FUNC_INSERT: begin
                new_cmd.op      = OP_INSERT;
                new_cmd.operand = s_due_time;
            end
            FUNC_QUERY:  new_cmd.op = OP_QUERY;
            FUNC_PURGE:  new_cmd.op = OP_PURGE;
            default:     new_cmd.op = OP_QUERY;
        endcase
    end

    // reserved code is taken and dropped: it yields no result
    assign push = s_valid && s_ready && (s_func != FUNC_RSVD);

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (cmd_pop) begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (push && !cmd_pop) begin
            fill_next = fill_reg + 2'd1;
        end else if (!push && cmd_pop) begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

// File: hw/rtl/dtq_back.sv
`timescale 1ns / 1ps
// Back end: sorted key cells with parallel compare, insert by local shift-up,
// purge by one-slot shift-down per cycle, and the result register. Uses dtq_pkg.
module dtq_back import dtq_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cmd_valid,
    input  cmd_t                cmd,
    output logic                cmd_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [KEY_W-1:0]    m_next_due,
    output logic                m_found,
    output logic [CNT_W-1:0]    m_removed_count,
    output logic [CNT_W-1:0]    m_entry_count
);

    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic {S_IDLE, S_PURGE} state_t;

    state_t               state_reg, state_next;
    logic [KEY_W-1:0]     key_reg   [CAPACITY];
    logic [KEY_W-1:0]     key_next  [CAPACITY];
    logic [CAPACITY-1:0]  valid_reg, valid_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        removed_reg, removed_next;
    logic [KEY_W-1:0]     now_reg, now_next;

    logic                 m_valid_reg;
    status_t              status_reg;
    logic [KEY_W-1:0]     next_due_reg;
    logic                 found_reg;
    logic [CNT_W-1:0]     removed_out_reg;
    logic [CNT_W-1:0]     entry_out_reg;

    logic [CAPACITY-1:0]  lt, eq, hit;
    logic                 dup, full, any_hit, head_lt, out_free;
    logic [KEY_W-1:0]     hit_key;
    logic                 do_insert, do_shift, load_res;
    status_t              res_status;
    logic [KEY_W-1:0]     res_next_due;
    logic                 res_found;
    logic [CW-1:0]        res_removed;

    function automatic logic [CNT_W-1:0] to_cnt(input logic [CW-1:0] v);
        logic [CW+CNT_W-1:0] w;
        w = {{CNT_W{1'b0}}, v};
        return w[CNT_W-1:0];
    endfunction

    // per-cell compare against the head command's operand
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            lt[i] = valid_reg[i] && (key_reg[i] < cmd.operand);
            eq[i] = valid_reg[i] && (key_reg[i] == cmd.operand);
        end
        hit[0] = valid_reg[0] && !lt[0];
        for (int i = 1; i < CAPACITY; i++) begin
            hit[i] = valid_reg[i] && !lt[i] && lt[i-1];
        end
        hit_key = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            hit_key = hit_key | (hit[i] ? key_reg[i] : '0);
        end
    end

    assign dup      = |eq;
    assign any_hit  = |hit;
    assign full     = valid_reg[CAPACITY-1];
    assign head_lt  = valid_reg[0] && (key_reg[0] < now_reg);
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        removed_next = removed_reg;
        now_next     = now_reg;
        cmd_pop      = 1'b0;
        do_insert    = 1'b0;
        do_shift     = 1'b0;
        load_res     = 1'b0;
        res_status   = ST_NONE;
        res_next_due = '0;
        res_found    = 1'b0;
        res_removed  = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (cmd_valid) begin
                    unique case (cmd.op)
                        OP_INSERT: begin
                            if (out_free) begin
                                cmd_pop  = 1'b1;
                                load_res = 1'b1;
                                priority if (dup) begin
                                    res_status = ST_DUPLICATE;
                                end else if (full) begin
                                    res_status = ST_FULL;
                                end else begin
                                    res_status = ST_INSERTED;
                                    do_insert  = 1'b1;
                                    count_next = count_reg + CW'(1);
                                end
                            end
                        end
                        OP_QUERY: begin
                            if (out_free) begin
                                cmd_pop      = 1'b1;
                                load_res     = 1'b1;
                                res_status   = any_hit ? ST_FOUND : ST_NONE;
                                res_next_due = hit_key;
                                res_found    = any_hit;
                            end
                        end
                        OP_PURGE: begin
                            cmd_pop      = 1'b1;
                            now_next     = cmd.operand;
                            removed_next = '0;
                            state_next   = S_PURGE;
                        end
                        default: ;
                    endcase
                end
            end
            S_PURGE: begin
                // overdue keys sit at the bottom; drop one per cycle
                if (head_lt) begin
                    do_shift     = 1'b1;
                    removed_next = removed_reg + CW'(1);
                    count_next   = count_reg - CW'(1);
                end else if (out_free) begin
                    load_res    = 1'b1;
                    res_status  = ST_PURGED;
                    res_removed = removed_reg;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // cell update: insert opens a gap at the boundary, purge shifts down
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            key_next[i] = key_reg[i];
        end
        valid_next = valid_reg;
        if (do_insert) begin
            if (!lt[0]) begin
                key_next[0] = cmd.operand;
            end
            valid_next[0] = 1'b1;
            for (int i = 1; i < CAPACITY; i++) begin
                if (!lt[i]) begin
                    key_next[i] = lt[i-1] ? cmd.operand : key_reg[i-1];
                end
                valid_next[i] = valid_reg[i] | valid_reg[i-1];
            end
        end else if (do_shift) begin
            for (int i = 0; i < CAPACITY - 1; i++) begin
                key_next[i]   = key_reg[i+1];
                valid_next[i] = valid_reg[i+1];
            end
            valid_next[CAPACITY-1] = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            valid_reg   <= '0;
            count_reg   <= '0;
            removed_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            count_reg   <= count_next;
            removed_reg <= removed_next;
            if (load_res) begin
                m_valid_reg     <= 1'b1;
                status_reg      <= res_status;
                next_due_reg    <= res_next_due;
                found_reg       <= res_found;
                removed_out_reg <= to_cnt(res_removed);
                entry_out_reg   <= to_cnt(count_next);
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        now_reg <= now_next;
        for (int i = 0; i < CAPACITY; i++) begin
            key_reg[i] <= key_next[i];
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = status_reg;
    assign m_next_due      = next_due_reg;
    assign m_found         = found_reg;
    assign m_removed_count = removed_out_reg;
    assign m_entry_count   = entry_out_reg;

endmodule

// File: hw/rtl/due_time_ordered_task_queue.sv
`timescale 1ns / 1ps
// Ordered set of due times in sorted register cells. An insert or query beat is registered
// in the queue stage, then executed into the result register. A purge drops one overdue key
// per cycle from the cells, then loads its result. Throughput: one insert or query per cycle
// while the result register is free; a purge holds the back end until its result is loaded.
// Synchronous active-low reset empties the store, the command FIFO and the result register.
module due_time_ordered_task_queue import dtq_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_func,
    input  logic [KEY_W-1:0]    s_due_time,
    input  logic [KEY_W-1:0]    s_now_time,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [KEY_W-1:0]    m_next_due,
    output logic                m_found,
    output logic [CNT_W-1:0]    m_removed_count,
    output logic [CNT_W-1:0]    m_entry_count
);

    logic cmd_valid;
    cmd_t cmd;
    logic cmd_pop;

    dtq_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_func     (s_func),
        .s_due_time (s_due_time),
        .s_now_time (s_now_time),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_pop    (cmd_pop)
    );

    dtq_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd_valid       (cmd_valid),
        .cmd             (cmd),
        .cmd_pop         (cmd_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_next_due      (m_next_due),
        .m_found         (m_found),
        .m_removed_count (m_removed_count),
        .m_entry_count   (m_entry_count)
    );

endmodule

// File: sim/tb_due_time_ordered_task_queue.sv
`timescale 1ns / 1ps
// Self-checking testbench for due_time_ordered_task_queue: directed and random
// insert/query/purge beats, checked against a sorted-set predictor in a scoreboard.
// Depends on dtq_pkg and the top-level RTL only.
module tb_due_time_ordered_task_queue;
    import dtq_pkg::*;

    localparam int CAPACITY     = 16;
    localparam int RANDOM_ITEMS = 600;
    localparam int LIMIT_CYCLES = 200000;
    localparam int MAX_REPORTS  = 10;
    localparam int POOL_SIZE    = 32;

    typedef logic [KEY_W-1:0] key_t;
    localparam key_t KEY_MAX = '1;

    typedef struct {
        status_t          status;
        key_t             next_due;
        logic             found;
        logic [CNT_W-1:0] removed;
        logic [CNT_W-1:0] entries;
    } outcome_t;

    // Sorted-set predictor plus the queue of outcomes still owed by the block
    class due_scoreboard;
        key_t     held[$];
        outcome_t awaited[$];
        int       mismatches = 0;

        function void note_beat(func_t func, key_t due, key_t now);
            outcome_t want;
            int       pos;
            if (func == FUNC_RSVD)
                return;
            want.status   = ST_INSERTED;
            want.next_due = '0;
            want.found    = 1'b0;
            want.removed  = '0;
            pos = 0;
            case (func)
                FUNC_INSERT: begin
                    while (pos < held.size() && held[pos] < due)
                        pos++;
                    // a duplicate wins over a full store
                    if (pos < held.size() && held[pos] == due)
                        want.status = ST_DUPLICATE;
                    else if (held.size() >= CAPACITY)
                        want.status = ST_FULL;
                    else
                        held.insert(pos, due);
                end
                FUNC_QUERY: begin
                    while (pos < held.size() && held[pos] < now)
                        pos++;
                    if (pos < held.size()) begin
                        want.status   = ST_FOUND;
                        want.next_due = held[pos];
                        want.found    = 1'b1;
                    end else begin
                        want.status = ST_NONE;
                    end
                end
                default: begin
                    while (pos < held.size() && held[pos] < now)
                        pos++;
                    want.status  = ST_PURGED;
                    want.removed = CNT_W'(pos);
                    repeat (pos) void'(held.pop_front());
                end
            endcase
            want.entries = CNT_W'(held.size());
            awaited.push_back(want);
        endfunction

        function void check_beat(outcome_t got);
            outcome_t want;
            if (awaited.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR: result beat with nothing expected: status=%0d next_due=%0h",
                             got.status, got.next_due);
                return;
            end
            want = awaited.pop_front();
            if (got.status !== want.status || got.next_due !== want.next_due ||
                got.found !== want.found || got.removed !== want.removed ||
                got.entries !== want.entries) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("ERROR: expected status=%0d next_due=%0h found=%0b removed=%0d entries=%0d",
                             want.status, want.next_due, want.found, want.removed, want.entries);
                    $display("       actual   status=%0d next_due=%0h found=%0b removed=%0d entries=%0d",
                             got.status, got.next_due, got.found, got.removed, got.entries);
                end
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [1:0]          s_func;
    key_t                s_due_time;
    key_t                s_now_time;
    logic                m_valid;
    logic                m_ready;
    logic [STATUS_W-1:0] m_status;
    key_t                m_next_due;
    logic                m_found;
    logic [CNT_W-1:0]    m_removed_count;
    logic [CNT_W-1:0]    m_entry_count;

    due_scoreboard sb = new;
    bit            burst;
    key_t          due_pool[POOL_SIZE];

    due_time_ordered_task_queue #(
        .CAPACITY(CAPACITY)
    ) u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_due_time      (s_due_time),
        .s_now_time      (s_now_time),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_next_due      (m_next_due),
        .m_found         (m_found),
        .m_removed_count (m_removed_count),
        .m_entry_count   (m_entry_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // Offer one beat after a random gap, none in a burst, and hold it until accepted
    task automatic send_beat(input func_t func, input key_t due, input key_t now);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 10);
        repeat (gap) begin
            @(negedge aclk);
            s_valid = 1'b0;
        end
        @(negedge aclk);
        s_valid    = 1'b1;
        s_func     = func;
        s_due_time = due;
        s_now_time = now;
        do @(posedge aclk); while (s_ready !== 1'b1);
        sb.note_beat(func, due, now);
    endtask

    function automatic key_t pick_due();
        if ($urandom_range(0, 99) < 65)
            return due_pool[$urandom_range(0, POOL_SIZE - 1)];
        return key_t'($urandom);
    endfunction

    // Mostly lands on or next to a stored key; purges lean on the low keys
    // so the store stays well populated
    function automatic key_t pick_now(bit for_purge);
        int   n;
        int   r;
        int   idx;
        key_t k;
        n = sb.held.size();
        r = $urandom_range(0, 99);
        if (n > 0 && r < 70) begin
            idx = for_purge ? $urandom_range(0, (n < 4) ? n - 1 : 3) : $urandom_range(0, n - 1);
            k = sb.held[idx];
            case ($urandom_range(0, 2))
                0:       return k;
                1:       return (k == KEY_MAX) ? k : k + 1'b1;
                default: return (k == '0) ? k : k - 1'b1;
            endcase
        end
        if (r < 80)
            return '0;
        if (r < 85)
            return KEY_MAX;
        return key_t'($urandom);
    endfunction

    initial begin : result_sink
        int       stall;
        outcome_t got;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            stall = burst ? 0 : $urandom_range(0, 10);
            repeat (stall) begin
                @(negedge aclk);
                m_ready = 1'b0;
            end
            @(negedge aclk);
            m_ready = 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            got.status   = status_t'(m_status);
            got.next_due = m_next_due;
            got.found    = m_found;
            got.removed  = m_removed_count;
            got.entries  = m_entry_count;
            sb.check_beat(got);
        end
    end

    initial begin : stimulus
        int done;
        int r;
        s_valid    = 1'b0;
        s_func     = FUNC_INSERT;
        s_due_time = '0;
        s_now_time = '0;
        aresetn    = 1'b0;
        burst      = 1'b0;
        due_pool[0] = '0;
        due_pool[1] = KEY_MAX;
        for (int i = 2; i < POOL_SIZE; i++)
            due_pool[i] = key_t'($urandom);
        repeat (11) @(negedge aclk);
        aresetn = 1'b1;

        // directed: empty store, extremes, duplicates, reserved code, full store
        send_beat(FUNC_QUERY, KEY_MAX, '0);
        send_beat(FUNC_PURGE, '0, KEY_MAX);
        send_beat(FUNC_INSERT, '0, KEY_MAX);
        send_beat(FUNC_INSERT, '0, '0);
        send_beat(FUNC_QUERY, '0, '0);
        send_beat(FUNC_QUERY, '0, KEY_MAX);
        send_beat(FUNC_RSVD, KEY_MAX, KEY_MAX);
        send_beat(FUNC_INSERT, KEY_MAX, '0);
        send_beat(FUNC_QUERY, '0, key_t'(1));
        for (int k = 1; k <= CAPACITY - 2; k++)
            send_beat(FUNC_INSERT, key_t'(k * 32'h0900_0000 + k), '0);
        send_beat(FUNC_INSERT, key_t'(32'h1234_5678), '0);
        send_beat(FUNC_INSERT, KEY_MAX, '0);
        send_beat(FUNC_PURGE, '0, KEY_MAX);

        // random: reserved codes are noise and do not count
        done = 0;
        while (done < RANDOM_ITEMS) begin
            if (done % 40 == 0)
                burst = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 4) begin
                send_beat(FUNC_RSVD, key_t'($urandom), key_t'($urandom));
            end else begin
                if (r < 52)
                    send_beat(FUNC_INSERT, pick_due(), key_t'($urandom));
                else if (r < 78)
                    send_beat(FUNC_QUERY, key_t'($urandom), pick_now(1'b0));
                else
                    send_beat(FUNC_PURGE, key_t'($urandom), pick_now(1'b1));
                done++;
            end
        end
        @(negedge aclk);
        s_valid = 1'b0;
        burst   = 1'b0;

        while (sb.pending() != 0)
            @(posedge aclk);
        // wait past the longest purge to catch any stray beat
        repeat (4 * CAPACITY) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/dtq_pkg.sv
hw/rtl/dtq_front.sv
hw/rtl/dtq_back.sv
hw/rtl/due_time_ordered_task_queue.sv
sim/tb_due_time_ordered_task_queue.sv
